// ----- hdl/dls_pkg.sv -----
// Shared constants, codes and types of the display latency sampler.
package dls_pkg;

	// Sizes of the latency history and of the statistics datapath.
	localparam int HISTORY_DEPTH = 16;
	localparam int LAT_W = 32;
	localparam int SLOT_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
	localparam int SUM_W = LAT_W + CNT_W;
	localparam int DIV_STEP_W = $clog2(SUM_W);

	// Queue between the sequencer and the statistics engine.
	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_PTR_W = 1;
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	// Operation codes of an input request.
	localparam logic [1:0] OP_TICK = 2'd0;
	localparam logic [1:0] OP_FRAME = 2'd1;
	localparam logic [1:0] OP_SENSOR = 2'd2;

	// Sample status codes.
	localparam logic [1:0] ST_NONE = 2'd0;
	localparam logic [1:0] ST_NEW = 2'd1;
	localparam logic [1:0] ST_MISSING = 2'd2;

	// Configuration register indexes and reset values.
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_WAIT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_WINDOW = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_WINDOW = 2'd2;
	localparam logic [LAT_W-1:0] CLEAR_WAIT_RST = 32'd200000;
	localparam logic [LAT_W-1:0] MIN_WINDOW_RST = 32'd200000;
	localparam logic [LAT_W-1:0] MAX_WINDOW_RST = 32'd500000;

	// One classified request handed from the sequencer to the statistics engine.
	typedef struct packed {
		logic patch_lit;
		logic [1:0] status;
		logic [LAT_W-1:0] latency;
	} dls_job_t;

endpackage

// ----- hdl/dls_if.sv -----
// Handshake channel interfaces of the display latency sampler.
interface dls_in_if import dls_pkg::*; ();
	logic valid;
	logic ready;
	logic [1:0] operation;
	logic [LAT_W-1:0] now_ticks;
	modport source(output valid, operation, now_ticks, input ready);
	modport sink(input valid, operation, now_ticks, output ready);
endinterface

interface dls_out_if import dls_pkg::*; ();
	logic valid;
	logic ready;
	logic patch_lit;
	logic [1:0] sample_news;
	logic [LAT_W-1:0] latest_latency;
	logic [LAT_W-1:0] mean_latency;
	logic [LAT_W-1:0] min_latency;
	logic [LAT_W-1:0] max_latency;
	logic [CNT_W-1:0] filled_count;
	modport source(output valid, patch_lit, sample_news, latest_latency, mean_latency,
		min_latency, max_latency, filled_count, input ready);
	modport sink(input valid, patch_lit, sample_news, latest_latency, mean_latency,
		min_latency, max_latency, filled_count, output ready);
endinterface

interface dls_cfg_if import dls_pkg::*; ();
	logic valid;
	logic ready;
	logic [CFG_IDX_W-1:0] index;
	logic [LAT_W-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ----- hdl/dls_front.sv -----
// Sequencer front end: configuration, patch sequence and edge capture.
module dls_front import dls_pkg::*; (
	input logic clk,
	input logic arst_n,
	dls_in_if.sink in_ch,
	dls_cfg_if.sink cfg_ch,
	output logic push_valid,
	input logic push_ready,
	output dls_job_t push_job
);

	localparam logic [2:0] PH_CLEAR = 3'd0;
	localparam logic [2:0] PH_WAIT_CLEAR = 3'd1;
	localparam logic [2:0] PH_START = 3'd2;
	localparam logic [2:0] PH_WAIT_SAMPLE = 3'd3;

	logic [LAT_W-1:0] clear_wait_q;
	logic [LAT_W-1:0] min_window_q;
	logic [LAT_W-1:0] max_window_q;

	logic [2:0] phase_q, phase_d;
	logic [LAT_W-1:0] start_q, start_d;
	logic [LAT_W-1:0] frame_time_q, frame_time_d;
	logic [LAT_W-1:0] sensor_time_q, sensor_time_d;
	logic frame_cap_q, frame_cap_d;
	logic sensor_cap_q, sensor_cap_d;
	logic lit_q, lit_d;
	logic [1:0] status;
	logic [LAT_W-1:0] elapsed;
	logic accept;

	// Every request goes to the queue as soon as it is accepted.
	assign cfg_ch.ready = 1'b1;
	assign in_ch.ready = push_ready;
	assign push_valid = in_ch.valid;
	assign accept = in_ch.valid && push_ready;
	assign elapsed = in_ch.now_ticks - start_q;

	// Next state of the sequencer and of the two captures.
	always_comb begin
		phase_d = phase_q;
		start_d = start_q;
		frame_time_d = frame_time_q;
		sensor_time_d = sensor_time_q;
		frame_cap_d = frame_cap_q;
		sensor_cap_d = sensor_cap_q;
		lit_d = lit_q;
		status = ST_NONE;
		case (in_ch.operation)
			OP_TICK: begin
				case (phase_q)
					PH_CLEAR: begin
						lit_d = 1'b0;
						phase_d = PH_WAIT_CLEAR;
						start_d = in_ch.now_ticks;
					end
					PH_WAIT_CLEAR: begin
						if (elapsed >= clear_wait_q) begin
							phase_d = PH_START;
							start_d = in_ch.now_ticks;
						end
					end
					PH_START: begin
						phase_d = PH_WAIT_SAMPLE;
						start_d = in_ch.now_ticks;
						lit_d = 1'b1;
						frame_cap_d = 1'b0;
						sensor_cap_d = 1'b0;
					end
					PH_WAIT_SAMPLE: begin
						if (elapsed >= min_window_q) begin
							if (elapsed > max_window_q) begin
								phase_d = PH_CLEAR;
								start_d = in_ch.now_ticks;
								status = ST_MISSING;
							end else if (frame_cap_q && sensor_cap_q) begin
								phase_d = PH_CLEAR;
								start_d = in_ch.now_ticks;
								status = (frame_time_q >= sensor_time_q) ? ST_MISSING : ST_NEW;
							end
						end
					end
					default: begin
						phase_d = PH_CLEAR;
						start_d = in_ch.now_ticks;
					end
				endcase
			end
			OP_FRAME: begin
				if (!frame_cap_q) begin
					frame_time_d = in_ch.now_ticks;
					frame_cap_d = 1'b1;
				end
			end
			OP_SENSOR: begin
				if (!sensor_cap_q) begin
					sensor_time_d = in_ch.now_ticks;
					sensor_cap_d = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// Request record for the statistics engine.
	always_comb begin
		push_job.patch_lit = lit_d;
		push_job.status = status;
		push_job.latency = sensor_time_q - frame_time_q;
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_wait_q <= CLEAR_WAIT_RST;
			min_window_q <= MIN_WINDOW_RST;
			max_window_q <= MAX_WINDOW_RST;
		end else if (cfg_ch.valid) begin
			case (cfg_ch.index)
				CFG_CLEAR_WAIT: clear_wait_q <= cfg_ch.data;
				CFG_MIN_WINDOW: min_window_q <= cfg_ch.data;
				CFG_MAX_WINDOW: max_window_q <= cfg_ch.data;
				default: begin
				end
			endcase
		end
	end

	// Sequencer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_CLEAR;
			start_q <= '0;
			frame_time_q <= '0;
			sensor_time_q <= '0;
			frame_cap_q <= 1'b1;
			sensor_cap_q <= 1'b1;
			lit_q <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_d;
			start_q <= start_d;
			frame_time_q <= frame_time_d;
			sensor_time_q <= sensor_time_d;
			frame_cap_q <= frame_cap_d;
			sensor_cap_q <= sensor_cap_d;
			lit_q <= lit_d;
		end
	end

	// The patch is lit throughout a sample window and dark throughout the clear wait.
	a_lit_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_WAIT_SAMPLE) |-> lit_q)
		else $error("patch dark during sample window");
	a_dark_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_WAIT_CLEAR) |-> !lit_q)
		else $error("patch lit during clear wait");

endmodule

// ----- hdl/dls_fifo.sv -----
// Short request queue between the sequencer and the statistics engine.
module dls_fifo import dls_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push_valid,
	output logic push_ready,
	input dls_job_t push_job,
	output logic pop_valid,
	input logic pop_ready,
	output dls_job_t pop_job
);

	dls_job_t slots_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;
	logic push;
	logic pop;

	assign push_ready = (count_q != FIFO_CNT_W'(FIFO_DEPTH));
	assign pop_valid = (count_q != '0);
	assign push = push_valid && push_ready;
	assign pop = pop_valid && pop_ready;
	assign pop_job = slots_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_job;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// The fill level never passes the queue depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FIFO_CNT_W'(FIFO_DEPTH))
		else $error("queue fill level out of range");

endmodule

// ----- hdl/dls_back.sv -----
// Statistics engine: latency history, walk for sum, min and max, serial mean divide.
module dls_back import dls_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic pop_valid,
	output logic pop_ready,
	input dls_job_t pop_job,
	dls_out_if.source out_ch
);

	localparam logic [1:0] BK_IDLE = 2'd0;
	localparam logic [1:0] BK_WALK = 2'd1;
	localparam logic [1:0] BK_DIV = 2'd2;
	localparam logic [1:0] BK_DONE = 2'd3;

	logic [1:0] state_q;
	logic [LAT_W-1:0] hist_mem [HISTORY_DEPTH];
	logic [LAT_W-1:0] rd_data_s1;
	logic rd_vld_s1;
	logic [SLOT_W-1:0] slot_q;
	logic [CNT_W-1:0] cnt_q;
	logic [LAT_W-1:0] last_q;
	logic lit_q;
	logic [1:0] status_q;
	logic [CNT_W-1:0] issue_q;
	logic [SUM_W-1:0] sum_q;
	logic [LAT_W-1:0] min_q;
	logic [LAT_W-1:0] max_q;
	logic [SUM_W-1:0] dvd_q;
	logic [CNT_W-1:0] rem_q;
	logic [DIV_STEP_W-1:0] step_q;
	logic out_valid_q;
	logic take;
	logic wr_en;
	logic rd_en;
	logic [SLOT_W-1:0] rd_addr;
	logic [CNT_W:0] trial;
	logic trial_ge;
	logic out_free;
	logic load_out;

	assign pop_ready = (state_q == BK_IDLE);
	assign take = pop_valid && pop_ready;
	assign wr_en = take && (pop_job.status == ST_NEW);
	assign rd_en = (state_q == BK_WALK) && (issue_q < cnt_q);
	assign rd_addr = issue_q[SLOT_W-1:0];
	assign trial = {rem_q, dvd_q[SUM_W-1]};
	assign trial_ge = (trial >= {1'b0, cnt_q});
	assign out_free = !out_valid_q || out_ch.ready;
	assign load_out = (state_q == BK_DONE) && out_free;
	assign out_ch.valid = out_valid_q;

	// History memory with a registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			hist_mem[slot_q] <= pop_job.latency;
		end
		rd_data_s1 <= hist_mem[rd_addr];
	end

	// Control: take a request, walk the filled entries, divide, hand over.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			slot_q <= '0;
			cnt_q <= '0;
			last_q <= '0;
			issue_q <= '0;
			rd_vld_s1 <= 1'b0;
			step_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				BK_IDLE: begin
					if (take) begin
						if (wr_en) begin
							last_q <= pop_job.latency;
							slot_q <= (slot_q == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 :
								slot_q + 1'b1;
							if (cnt_q != CNT_W'(HISTORY_DEPTH)) begin
								cnt_q <= cnt_q + 1'b1;
							end
						end
						issue_q <= '0;
						state_q <= BK_WALK;
					end
				end
				BK_WALK: begin
					if (rd_en) begin
						issue_q <= issue_q + 1'b1;
					end else if (!rd_vld_s1) begin
						step_q <= '0;
						state_q <= (cnt_q == '0) ? BK_DONE : BK_DIV;
					end
				end
				BK_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == DIV_STEP_W'(SUM_W - 1)) begin
						state_q <= BK_DONE;
					end
				end
				BK_DONE: begin
					if (out_free) begin
						state_q <= BK_IDLE;
					end
				end
				default: begin
					state_q <= BK_IDLE;
				end
			endcase
		end
	end

	// Datapath: request fields, running statistics and the restoring divider.
	always_ff @(posedge clk) begin
		if (take) begin
			lit_q <= pop_job.patch_lit;
			status_q <= pop_job.status;
			sum_q <= '0;
			min_q <= '1;
			max_q <= '0;
		end
		if (rd_vld_s1) begin
			sum_q <= sum_q + SUM_W'(rd_data_s1);
			if (rd_data_s1 < min_q) begin
				min_q <= rd_data_s1;
			end
			if (rd_data_s1 > max_q) begin
				max_q <= rd_data_s1;
			end
		end
		if ((state_q == BK_WALK) && !rd_en && !rd_vld_s1) begin
			dvd_q <= sum_q;
			rem_q <= '0;
		end
		if (state_q == BK_DIV) begin
			rem_q <= trial_ge ? CNT_W'(trial - {1'b0, cnt_q}) : trial[CNT_W-1:0];
			dvd_q <= {dvd_q[SUM_W-2:0], trial_ge};
		end
	end

	// Output register: the engine moves on while a result waits to be taken.
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_ch.patch_lit <= lit_q;
			out_ch.sample_news <= status_q;
			out_ch.latest_latency <= last_q;
			out_ch.filled_count <= cnt_q;
			if (cnt_q == '0) begin
				out_ch.mean_latency <= '0;
				out_ch.min_latency <= '0;
				out_ch.max_latency <= '0;
			end else begin
				out_ch.mean_latency <= dvd_q[LAT_W-1:0];
				out_ch.min_latency <= min_q;
				out_ch.max_latency <= max_q;
			end
		end
	end

	// The fill count saturates at the history depth.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(HISTORY_DEPTH))
		else $error("history fill count out of range");
	// A recorded sample always leaves at least one filled entry.
	a_cnt_after_store: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> (cnt_q != '0))
		else $error("history empty after a recorded sample");

endmodule

// ----- hdl/display_latency_sampler_core.sv -----
// Top level of the display latency sampler.
// The block takes sequencer ticks, frame edges and sensor edges, each with a timestamp, and
// returns one result per request: the patch level, whether this request recorded or missed a
// sample, and the latest, mean, min and max latency over the filled history entries. The
// front end takes a request whenever its two-entry queue has room. The statistics engine
// then serves one request at a time: it takes the request, walks the N filled history
// entries (N at least one, at most sixteen) through its registered read port, runs the
// one-bit-per-cycle mean divider and loads the output register. With an empty history the
// divider is skipped. It takes no new request before it has loaded the result of the last.
// The load waits while an earlier result still sits unread in the output register. That
// engine sets the sustained rate. Configuration writes are taken in any cycle and are meant
// to be issued only while the block is idle.
module display_latency_sampler_core import dls_pkg::*; (
	input logic clk,
	input logic arst_n,
	dls_in_if.sink in_ch,
	dls_cfg_if.sink cfg_ch,
	dls_out_if.source out_ch
);

	logic push_valid;
	logic push_ready;
	dls_job_t push_job;
	logic pop_valid;
	logic pop_ready;
	dls_job_t pop_job;

	dls_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.cfg_ch(cfg_ch),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_job(push_job)
	);

	dls_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_job(push_job),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_job(pop_job)
	);

	dls_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_job(pop_job),
		.out_ch(out_ch)
	);

endmodule

// ----- test/tb_display_latency_sampler_core.sv -----
// Self-checking testbench of the display latency sampler core, with its own latency predictor.
module tb_display_latency_sampler_core;
	timeunit 1ns;
	timeprecision 1ps;
	import dls_pkg::*;

	// Operation code that the block has no use for.
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int RUN_LIMIT = 1000000;
	localparam int RANDOM_ITEMS = 1650;
	localparam int SETTING_COUNT = 12;
	localparam int DRAIN_CYCLES = 80;
	localparam int PRINT_CAP = 40;

	// Phases of the patch sequence.
	typedef enum logic [2:0] {
		SEQ_CLEAR,
		SEQ_WAIT_CLEAR,
		SEQ_LIGHT,
		SEQ_WAIT_SAMPLE
	} seq_phase_e;

	// One result as seen on the output channel.
	typedef struct packed {
		logic patch_lit;
		logic [1:0] status;
		logic [LAT_W-1:0] latest;
		logic [LAT_W-1:0] mean;
		logic [LAT_W-1:0] lo;
		logic [LAT_W-1:0] hi;
		logic [CNT_W-1:0] filled;
	} latency_report_t;

	// One row of the directed stimulus table.
	typedef struct {
		logic [1:0] op;
		logic [LAT_W-1:0] stamp;
		bit typed;
		latency_report_t want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;

	dls_in_if in_ch();
	dls_cfg_if cfg_ch();
	dls_out_if out_ch();

	display_latency_sampler_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.cfg_ch(cfg_ch),
		.out_ch(out_ch)
	);

	// Predictor state and configuration.
	logic [LAT_W-1:0] cfg_clear_wait;
	logic [LAT_W-1:0] cfg_min_window;
	logic [LAT_W-1:0] cfg_max_window;
	seq_phase_e seq_phase;
	logic [LAT_W-1:0] seq_start;
	logic [LAT_W-1:0] frame_stamp;
	logic [LAT_W-1:0] sensor_stamp;
	logic [LAT_W-1:0] last_latency;
	logic frame_held;
	logic sensor_held;
	logic patch_on;
	logic [LAT_W-1:0] history [HISTORY_DEPTH];
	int unsigned write_slot;
	int unsigned filled;

	// Expected results in request order, and the directed table.
	latency_report_t pending_reports[$];
	stim_row_t directed_rows[$];

	logic [LAT_W-1:0] stamp_now = '0;
	int unsigned sent_count = 0;
	int unsigned taken_count = 0;
	int unsigned cycle_count = 0;
	int mismatches = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Print one line per mismatch, up to a cap, and count every one.
	task automatic report_mismatch(input string field, input logic [LAT_W-1:0] got,
		input logic [LAT_W-1:0] want);
		if (mismatches < PRINT_CAP) begin
			$display("%0t: mismatch in %s: got %0h, expected %0h", $realtime, field, got, want);
		end
		mismatches++;
	endtask

	task automatic reset_model();
		cfg_clear_wait = CLEAR_WAIT_RST;
		cfg_min_window = MIN_WINDOW_RST;
		cfg_max_window = MAX_WINDOW_RST;
		seq_phase = SEQ_CLEAR;
		seq_start = '0;
		frame_stamp = '0;
		sensor_stamp = '0;
		last_latency = '0;
		frame_held = 1'b1;
		sensor_held = 1'b1;
		patch_on = 1'b0;
		write_slot = 0;
		filled = 0;
	endtask

	// Advance the predictor by one request and return the result it should produce.
	function automatic latency_report_t predict_report(input logic [1:0] op,
		input logic [LAT_W-1:0] now);
		logic [LAT_W-1:0] elapsed;
		logic [1:0] news;
		logic [63:0] total;
		latency_report_t r;
		elapsed = now - seq_start;
		news = ST_NONE;
		if (op == OP_TICK) begin
			case (seq_phase)
				SEQ_CLEAR: begin
					patch_on = 1'b0;
					seq_phase = SEQ_WAIT_CLEAR;
					seq_start = now;
				end
				SEQ_WAIT_CLEAR: begin
					if (elapsed >= cfg_clear_wait) begin
						seq_phase = SEQ_LIGHT;
						seq_start = now;
					end
				end
				SEQ_LIGHT: begin
					seq_phase = SEQ_WAIT_SAMPLE;
					seq_start = now;
					patch_on = 1'b1;
					frame_held = 1'b0;
					sensor_held = 1'b0;
				end
				SEQ_WAIT_SAMPLE: begin
					// Nothing is decided before the minimum window has passed.
					if (elapsed >= cfg_min_window) begin
						if (elapsed > cfg_max_window) begin
							seq_phase = SEQ_CLEAR;
							seq_start = now;
							news = ST_MISSING;
						end else if (frame_held && sensor_held) begin
							seq_phase = SEQ_CLEAR;
							seq_start = now;
							if (frame_stamp >= sensor_stamp) begin
								news = ST_MISSING;
							end else begin
								last_latency = sensor_stamp - frame_stamp;
								history[write_slot] = last_latency;
								write_slot = (write_slot + 1) % HISTORY_DEPTH;
								if (filled < HISTORY_DEPTH) filled++;
								news = ST_NEW;
							end
						end
					end
				end
				default: begin
					seq_phase = SEQ_CLEAR;
					seq_start = now;
				end
			endcase
		end else if (op == OP_FRAME) begin
			if (!frame_held) begin
				frame_stamp = now;
				frame_held = 1'b1;
			end
		end else if (op == OP_SENSOR) begin
			if (!sensor_held) begin
				sensor_stamp = now;
				sensor_held = 1'b1;
			end
		end

		// Statistics over the filled part of the ring; all zero while it is empty.
		r.patch_lit = patch_on;
		r.status = news;
		r.latest = last_latency;
		r.filled = filled[CNT_W-1:0];
		r.mean = '0;
		r.lo = '0;
		r.hi = '0;
		total = '0;
		if (filled > 0) begin
			r.lo = '1;
			for (int i = 0; i < int'(filled); i++) begin
				total = total + 64'(history[i]);
				if (history[i] > r.hi) r.hi = history[i];
				if (history[i] < r.lo) r.lo = history[i];
			end
			total = total / 64'(filled);
			r.mean = total[LAT_W-1:0];
		end
		return r;
	endfunction

	// Random operation, leaning toward edges while the patch waits for its captures.
	function automatic logic [1:0] pick_operation();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 4) return OP_UNUSED;
		if (seq_phase == SEQ_WAIT_SAMPLE && !(frame_held && sensor_held)) begin
			return (roll < 30) ? OP_TICK : ((roll < 65) ? OP_FRAME : OP_SENSOR);
		end
		return (roll < 70) ? OP_TICK : ((roll < 85) ? OP_FRAME : OP_SENSOR);
	endfunction

	// Next timestamp: mostly small steps, often right at a window edge, sometimes a jump.
	function automatic logic [LAT_W-1:0] next_stamp(input logic [1:0] op);
		int unsigned roll;
		logic [LAT_W-1:0] aim;
		roll = $urandom_range(0, 99);
		if (roll < 8) begin
			stamp_now = $urandom;
		end else if (op == OP_TICK && roll < 50 &&
			(seq_phase == SEQ_WAIT_CLEAR || seq_phase == SEQ_WAIT_SAMPLE)) begin
			if (seq_phase == SEQ_WAIT_CLEAR) begin
				aim = cfg_clear_wait;
			end else begin
				case ($urandom_range(0, 2))
					0: aim = cfg_min_window;
					1: aim = cfg_max_window;
					default: aim = cfg_min_window +
						($urandom % ((cfg_max_window - cfg_min_window) | 32'd1));
				endcase
			end
			stamp_now = seq_start + aim + $urandom_range(0, 2) - 32'd1;
		end else begin
			stamp_now = stamp_now + $urandom_range(0, 12);
		end
		return stamp_now;
	endfunction

	task automatic add_row(input logic [1:0] op, input logic [LAT_W-1:0] stamp);
		stim_row_t row;
		row.op = op;
		row.stamp = stamp;
		row.typed = 1'b0;
		row.want = '0;
		directed_rows.push_back(row);
	endtask

	// Row whose result is known outright; mean, min and max equal the one stored value.
	task automatic add_checked_row(input logic [1:0] op, input logic [LAT_W-1:0] stamp,
		input logic lit, input logic [1:0] status, input logic [LAT_W-1:0] stat,
		input logic [CNT_W-1:0] cnt);
		stim_row_t row;
		row.op = op;
		row.stamp = stamp;
		row.typed = 1'b1;
		row.want.patch_lit = lit;
		row.want.status = status;
		row.want.latest = stat;
		row.want.mean = stat;
		row.want.lo = stat;
		row.want.hi = stat;
		row.want.filled = cnt;
		directed_rows.push_back(row);
	endtask

	// Issue one request after a random gap and record what it should return.
	task automatic send_item(input logic [1:0] op, input logic [LAT_W-1:0] stamp, input bit typed,
		input latency_report_t want);
		int unsigned gap;
		bit hold;
		latency_report_t predicted;
		gap = ((sent_count % 64) < 12) ? 0 : $urandom_range(0, 15);
		hold = ($urandom_range(0, 149) == 0);
		if (gap != 0 || hold) begin
			in_ch.valid <= 1'b0;
			// Now and then hold off until every outstanding result is back.
			if (hold) do @(posedge clk); while (pending_reports.size() != 0);
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.operation <= op;
		in_ch.now_ticks <= stamp;
		do @(posedge clk); while (!in_ch.ready);
		predicted = predict_report(op, stamp);
		pending_reports.push_back(typed ? want : predicted);
		sent_count++;
	endtask

	// One configuration write; the caller lowers valid after the last one.
	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [LAT_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		case (idx)
			CFG_CLEAR_WAIT: cfg_clear_wait = value;
			CFG_MIN_WINDOW: cfg_min_window = value;
			CFG_MAX_WINDOW: cfg_max_window = value;
			default: ;
		endcase
	endtask

	task automatic load_settings(input logic [LAT_W-1:0] clear_v, input logic [LAT_W-1:0] min_v,
		input logic [LAT_W-1:0] max_v);
		write_register(CFG_CLEAR_WAIT, clear_v);
		write_register(CFG_MIN_WINDOW, min_v);
		write_register(CFG_MAX_WINDOW, max_v);
		cfg_ch.valid <= 1'b0;
	endtask

	// Stop requests and let the block drain completely.
	task automatic wait_idle();
		in_ch.valid <= 1'b0;
		while (pending_reports.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Request side: directed table, then random phases under several settings.
	initial begin : stimulus
		int unsigned counted;
		int unsigned min_v;
		logic [1:0] op;
		in_ch.valid = 1'b0;
		in_ch.operation = OP_TICK;
		in_ch.now_ticks = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = CFG_CLEAR_WAIT;
		cfg_ch.data = '0;
		arst_n = 1'b0;
		reset_model();

		// Empty history, idle edges and the undefined operation.
		add_checked_row(OP_TICK, 32'd0, 1'b0, ST_NONE, 32'd0, 5'd0);
		add_checked_row(OP_UNUSED, 32'hffff_ffff, 1'b0, ST_NONE, 32'd0, 5'd0);
		add_checked_row(OP_FRAME, 32'd5, 1'b0, ST_NONE, 32'd0, 5'd0);
		add_checked_row(OP_SENSOR, 32'd6, 1'b0, ST_NONE, 32'd0, 5'd0);
		// Clear wait just short of and at its limit, then light the patch.
		add_row(OP_TICK, 32'd199999);
		add_row(OP_TICK, 32'd200000);
		add_checked_row(OP_TICK, 32'd200010, 1'b1, ST_NONE, 32'd0, 5'd0);
		add_row(OP_FRAME, 32'd200100);
		add_row(OP_SENSOR, 32'd200350);
		// One tick short of the minimum window, then a good sample of 250.
		add_row(OP_TICK, 32'd400009);
		add_checked_row(OP_TICK, 32'd400010, 1'b1, ST_NEW, 32'd250, 5'd1);
		add_row(OP_TICK, 32'd400020);
		// Timestamps wrap; the sensor comes before the frame, so the sample is missing.
		add_row(OP_TICK, 32'hffff_fff0);
		add_row(OP_TICK, 32'hffff_fff8);
		add_row(OP_SENSOR, 32'hffff_fffa);
		add_row(OP_FRAME, 32'hffff_ffff);
		add_checked_row(OP_TICK, 32'd199992, 1'b1, ST_MISSING, 32'd250, 5'd1);
		add_row(OP_TICK, 32'd199993);
		add_row(OP_TICK, 32'd199993);
		add_row(OP_TICK, 32'd399993);
		add_row(OP_TICK, 32'd399993);
		// Maximum window exceeded with no captures at all.
		add_checked_row(OP_TICK, 32'd899994, 1'b1, ST_MISSING, 32'd250, 5'd1);
		add_row(OP_FRAME, 32'd900000);
		add_row(OP_TICK, 32'd900010);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[n]) begin
			send_item(directed_rows[n].op, directed_rows[n].stamp, directed_rows[n].typed,
				directed_rows[n].want);
		end

		for (int p = 0; p < SETTING_COUNT; p++) begin
			wait_idle();
			case (p % 6)
				0: load_settings(32'd0, 32'd0, 32'd0);
				2: load_settings(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
				4: begin
					// Minimum above maximum: every sample ends up missing.
					min_v = $urandom_range(20, 80);
					load_settings($urandom_range(0, 30), min_v, $urandom_range(0, min_v - 1));
				end
				5: load_settings($urandom, $urandom, $urandom);
				default: begin
					min_v = $urandom_range(0, 40);
					load_settings($urandom_range(0, 30), min_v, min_v + $urandom_range(0, 80));
				end
			endcase
			counted = 0;
			while (counted < RANDOM_ITEMS / SETTING_COUNT) begin
				op = pick_operation();
				send_item(op, next_stamp(op), 1'b0, '0);
				if (op != OP_UNUSED) counted++;
			end
		end

		wait_idle();
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// Result side: random stalls, each result checked against the oldest expectation.
	initial begin : result_sink
		int unsigned stall;
		latency_report_t got;
		latency_report_t want;
		out_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = ((taken_count % 50) < 10) ? 0 : $urandom_range(0, 15);
			if (stall != 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!out_ch.valid);
			got.patch_lit = out_ch.patch_lit;
			got.status = out_ch.sample_news;
			got.latest = out_ch.latest_latency;
			got.mean = out_ch.mean_latency;
			got.lo = out_ch.min_latency;
			got.hi = out_ch.max_latency;
			got.filled = out_ch.filled_count;
			taken_count++;
			if (pending_reports.size() == 0) begin
				report_mismatch("result with nothing outstanding", LAT_W'(got.status),
					LAT_W'(ST_NONE));
			end else begin
				want = pending_reports.pop_front();
				if (got.patch_lit !== want.patch_lit)
					report_mismatch("patch_lit", LAT_W'(got.patch_lit), LAT_W'(want.patch_lit));
				if (got.status !== want.status)
					report_mismatch("sample_news", LAT_W'(got.status), LAT_W'(want.status));
				if (got.latest !== want.latest)
					report_mismatch("latest_latency", got.latest, want.latest);
				if (got.mean !== want.mean)
					report_mismatch("mean_latency", got.mean, want.mean);
				if (got.lo !== want.lo)
					report_mismatch("min_latency", got.lo, want.lo);
				if (got.hi !== want.hi)
					report_mismatch("max_latency", got.hi, want.hi);
				if (got.filled !== want.filled)
					report_mismatch("filled_count", LAT_W'(got.filled), LAT_W'(want.filled));
			end
		end
	end

	// Watchdog on the total run length.
	initial begin : run_watchdog
		while (cycle_count < RUN_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Mismatches found");
		$finish;
	end

endmodule
